/* hdl/kptl_pkg.sv */
package kptl_pkg;

	localparam int unsigned KEY_W = 24;
	localparam int unsigned PTS_W = 4;
	localparam int unsigned CNT_W = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [KEY_W-1:0] key_name;
		logic [PTS_W-1:0] points;
	} in_t;

	typedef struct packed {
		logic [KEY_W-1:0] leader_name;
		logic [CNT_W-1:0] leader_points;
		logic             dropped;
	} out_t;

	// item travelling along the chain, with the running leader
	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [PTS_W-1:0] pts;
		logic             done;
		logic             have;
		logic [KEY_W-1:0] best_key;
		logic [CNT_W-1:0] best_cnt;
	} pkt_t;

endpackage

/* hdl/kptl_cell.sv */
module kptl_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  kptl_pkg::pkt_t pkt_in,
	output kptl_pkg::pkt_t pkt_out
);
	import kptl_pkg::*;

	logic             used_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;

	logic             hit;
	logic             fill;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] cnt_new;
	logic             used_new;
	logic [KEY_W-1:0] key_new;
	pkt_t             pkt_nxt;

	assign hit  = pkt_in.vld && !pkt_in.done && used_q && (key_q == pkt_in.key);
	assign fill = pkt_in.vld && !pkt_in.done && !used_q && (pkt_in.pts != '0);
	assign sum  = {1'b0, cnt_q} + {{(CNT_W+1-PTS_W){1'b0}}, pkt_in.pts};

	always_comb begin
		cnt_new  = cnt_q;
		key_new  = key_q;
		used_new = used_q;
		if (hit) begin
			cnt_new = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
		end else if (fill) begin
			cnt_new  = {{(CNT_W-PTS_W){1'b0}}, pkt_in.pts};
			key_new  = pkt_in.key;
			used_new = 1'b1;
		end
	end

	always_comb begin
		pkt_nxt = pkt_in;
		// first free cell ends the search, stored or not
		if (pkt_in.vld && !pkt_in.done && (hit || !used_q)) begin
			pkt_nxt.done = 1'b1;
		end
		if (used_new && (!pkt_in.have || cnt_new >= pkt_in.best_cnt)) begin
			pkt_nxt.have     = 1'b1;
			pkt_nxt.best_key = key_new;
			pkt_nxt.best_cnt = cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (pkt_in.vld) begin
			used_q <= used_new;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_in.vld) begin
			key_q <= key_new;
			cnt_q <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_out <= '0;
		end else begin
			pkt_out <= pkt_nxt;
		end
	end

endmodule

/* hdl/keyed_point_tally_leader.sv */
// channel   ports                      transfer when
// -------   ------------------------   -----------------------------
// item in   start, busy, item          start high and busy low
// result    result_strobe, result      result_strobe high (one cycle)
//
// One item enters per cycle; busy stays low. Each item walks the row of
// ENTRIES cells, one cell per cycle, each cell registering it, so results
// come out in order. Reset empties every cell at once; no clearing pass.
// The receiver cannot stall, so nothing ever backs up.
module keyed_point_tally_leader #(
	parameter int unsigned ENTRIES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kptl_pkg::in_t  item,
	output logic          result_strobe,
	output kptl_pkg::out_t result
);
	import kptl_pkg::*;

	pkt_t head;
	pkt_t chain [0:ENTRIES];

	always_comb begin
		head          = '0;
		head.vld      = start && !busy;
		head.key      = item.key_name;
		head.pts      = item.points;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kptl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pkt_in  (chain[i]),
			.pkt_out (chain[i+1])
		);
	end

	assign busy          = 1'b0;
	assign result_strobe = chain[ENTRIES].vld;

	always_comb begin
		result.leader_name   = chain[ENTRIES].have ? chain[ENTRIES].best_key : '0;
		result.leader_points = chain[ENTRIES].have ? chain[ENTRIES].best_cnt : '0;
		result.dropped       = !chain[ENTRIES].done;
	end

endmodule

/* test/tb_keyed_point_tally_leader.sv */
`timescale 1ns / 1ps

module tb_keyed_point_tally_leader;

	import kptl_pkg::*;

	localparam int unsigned ENTRIES = 128;
	localparam int unsigned RANDOM_ITEMS = 1250;

	typedef struct {
		in_t  it;
		bit   typed;
		out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_t  item = '0;
	logic busy;
	logic result_strobe;
	out_t result;

	logic [KEY_W-1:0] tally_keys [ENTRIES];
	logic [CNT_W-1:0] tally_counts [ENTRIES];
	int unsigned      tally_used;

	out_t leader_q [$];
	int   mismatches = 0;
	int   burst_left = 0;

	dir_row_t dir_rows [20] = '{
		'{'{24'h414243, 4'd0},  1'b1, '{24'h000000, 16'd0,  1'b0}},
		'{'{24'h000000, 4'd0},  1'b1, '{24'h000000, 16'd0,  1'b0}},
		'{'{24'h000000, 4'd1},  1'b1, '{24'h000000, 16'd1,  1'b0}},
		'{'{24'hFFFFFF, 4'd15}, 1'b1, '{24'hFFFFFF, 16'd15, 1'b0}},
		'{'{24'h000000, 4'd14}, 1'b1, '{24'hFFFFFF, 16'd15, 1'b0}},
		'{'{24'hFFFFFF, 4'd0},  1'b1, '{24'hFFFFFF, 16'd15, 1'b0}},
		'{'{24'h000000, 4'd1},  1'b1, '{24'h000000, 16'd16, 1'b0}},
		'{'{24'h414141, 4'd15}, 1'b1, '{24'h000000, 16'd16, 1'b0}},
		'{'{24'h414141, 4'd1},  1'b1, '{24'h414141, 16'd16, 1'b0}},
		'{'{24'h800000, 4'd15}, 1'b0, '0},
		'{'{24'h7FFFFF, 4'd8},  1'b0, '0},
		'{'{24'h800000, 4'd15}, 1'b0, '0},
		'{'{24'h555555, 4'd0},  1'b0, '0},
		'{'{24'hAAAAAA, 4'd1},  1'b0, '0},
		'{'{24'h000001, 4'd15}, 1'b0, '0},
		'{'{24'h123456, 4'd7},  1'b0, '0},
		'{'{24'h000000, 4'd15}, 1'b0, '0},
		'{'{24'hFEDCBA, 4'd9},  1'b0, '0},
		'{'{24'hFFFFFF, 4'd15}, 1'b0, '0},
		'{'{24'h414141, 4'd0},  1'b0, '0}
	};

	keyed_point_tally_leader #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_keyed_point_tally_leader NOT OK");
		$finish;
	end

	function automatic int tally_slot(input logic [KEY_W-1:0] key);
		for (int i = 0; i < tally_used; i++)
			if (tally_keys[i] == key)
				return i;
		return -1;
	endfunction

	function automatic out_t tally_update(input in_t it);
		out_t r;
		int slot;
		int lead;
		logic [CNT_W:0] sum;
		r = '0;
		slot = tally_slot(it.key_name);
		if (slot >= 0) begin
			sum = {1'b0, tally_counts[slot]} + (CNT_W+1)'(it.points);
			tally_counts[slot] = (sum > COUNT_MAX) ? COUNT_MAX : sum[CNT_W-1:0];
		end else if (tally_used >= ENTRIES) begin
			r.dropped = 1'b1;
		end else if (it.points != 0) begin
			tally_keys[tally_used] = it.key_name;
			tally_counts[tally_used] = CNT_W'(it.points);
			tally_used++;
		end
		lead = 0;
		for (int i = 0; i < tally_used; i++)
			if (tally_counts[i] >= tally_counts[lead])
				lead = i;
		if (tally_used != 0) begin
			r.leader_name = tally_keys[lead];
			r.leader_points = tally_counts[lead];
		end
		return r;
	endfunction

	task automatic post_item(input in_t it, input bit typed, input out_t want);
		int gap;
		out_t pred;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pred = tally_update(it);
		leader_q.push_back(typed ? want : pred);
		burst_left--;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (leader_q.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && result_strobe) begin
			if (leader_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: name %h points %0d dropped %0b",
						result.leader_name, result.leader_points, result.dropped);
			end else begin
				want = leader_q.pop_front();
				if (result.leader_name !== want.leader_name ||
					result.leader_points !== want.leader_points ||
					result.dropped !== want.dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
							want.leader_name, want.leader_points, want.dropped,
							result.leader_name, result.leader_points, result.dropped);
				end
			end
		end
	end

	initial begin
		int sel;
		int idx;
		logic [KEY_W-1:0] k;
		logic [PTS_W-1:0] p;
		for (int i = 0; i < ENTRIES; i++) begin
			tally_keys[i] = '0;
			tally_counts[i] = '0;
		end
		tally_used = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			post_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		drain_results();

		// mostly repeat hits on stored keys, the rest fill the table and then drop
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55 && tally_used != 0) begin
				k = tally_keys[$urandom_range(0, tally_used - 1)];
			end else if (sel < 70) begin
				k[23:16] = 8'(8'h41 + $urandom_range(0, 25));
				k[15:8] = 8'(8'h41 + $urandom_range(0, 25));
				k[7:0] = 8'(8'h41 + $urandom_range(0, 25));
			end else begin
				k = KEY_W'($urandom());
			end
			p = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
			post_item('{k, p}, 1'b0, '0);
		end
		drain_results();

		// a hit and a zero-point hit, then new keys against the full table
		post_item('{tally_keys[1], 4'd15}, 1'b0, '0);
		post_item('{tally_keys[1], 4'd0}, 1'b0, '0);
		for (int n = 0; n < 4; n++) begin
			do begin
				k = KEY_W'($urandom());
				idx = tally_slot(k);
			end while (idx >= 0);
			post_item('{k, 4'(n == 0 ? 0 : $urandom_range(1, 15))}, 1'b0, '0);
		end
		start <= 1'b0;

		@(posedge clk);
		while (leader_q.size() != 0) @(posedge clk);
		repeat (ENTRIES + 16) @(posedge clk);
		if (mismatches == 0)
			$display("tb_keyed_point_tally_leader OK");
		else
			$display("tb_keyed_point_tally_leader NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hdl/kptl_pkg.sv
hdl/kptl_cell.sv
hdl/keyed_point_tally_leader.sv
test/tb_keyed_point_tally_leader.sv
